>>> sv/two_level_priority_fifo_core_defines.svh
// Assertion macros shared by the two-level priority FIFO core.
`ifndef TWO_LEVEL_PRIORITY_FIFO_CORE_DEFINES_SVH
`define TWO_LEVEL_PRIORITY_FIFO_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that cons holds in the same cycle whenever ante holds.
`define TLPF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlpf check failed");
// Check that cons holds in the cycle after ante holds.
`define TLPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlpf check failed");
`else
`define TLPF_ASSERT_SAME(label, clk, rst, ante, cons)
`define TLPF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/tlpf_pkg.sv
// Types and constants of the two-level priority FIFO core.
package tlpf_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int ID_W                = 16;
   localparam int CODE_W              = 8;
   localparam int COUNT_OUT_W         = 5;
   localparam int CMDQ_DEPTH          = 2;

   typedef enum logic [1:0] {
      ST_ADDED   = 2'd0,
      ST_SERVED  = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_DROPPED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD_LOW  = 2'd0,
      OP_ADD_HIGH = 2'd1,
      OP_SERVE    = 2'd2
   } op_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_READ = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [ID_W-1:0]     entry_id;
      logic [CODE_W-1:0]   entry_code;
   } cmd_type;

   typedef struct packed {
      status_type               status;
      logic                     from_high;
      logic [ID_W-1:0]          served_id;
      logic [CODE_W-1:0]        served_code;
      logic [COUNT_OUT_W-1:0]   high_count;
      logic [COUNT_OUT_W-1:0]   low_count;
   } rsp_payload_type;

endpackage

>>> sv/tlpf_if.sv
// Request and response channel interfaces of the two-level priority FIFO core.
interface tlpf_req_if import tlpf_pkg::*;;
   logic                valid;
   logic                ready;
   logic                action;
   logic                to_high;
   logic [ID_W-1:0]     entry_id;
   logic [CODE_W-1:0]   entry_code;

   modport source (output valid, action, to_high, entry_id, entry_code, input ready);
   modport sink   (input valid, action, to_high, entry_id, entry_code, output ready);
endinterface

interface tlpf_rsp_if import tlpf_pkg::*;;
   logic                     valid;
   logic                     ready;
   status_type               status;
   logic                     from_high;
   logic [ID_W-1:0]          served_id;
   logic [CODE_W-1:0]        served_code;
   logic [COUNT_OUT_W-1:0]   high_count;
   logic [COUNT_OUT_W-1:0]   low_count;

   modport source (output valid, status, from_high, served_id, served_code, high_count,
                   low_count, input ready);
   modport sink   (input valid, status, from_high, served_id, served_code, high_count,
                   low_count, output ready);
endinterface

>>> sv/tlpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tlpf_ram import tlpf_pkg::*; #(
   parameter int WIDTH = ID_W + CODE_W,
   parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]          wr_data,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tlpf_front.sv
// Front end: accept request transfers, classify them and queue commands.
module tlpf_front import tlpf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   tlpf_req_if.sink     req_ch,
   output logic         cmd_valid,
   output cmd_type      cmd,
   input  logic         cmd_pop
);

   localparam int QPtrW = $clog2(CMDQ_DEPTH);
   localparam int QCntW = $clog2(CMDQ_DEPTH + 1);

   cmd_type            entry_ff [CMDQ_DEPTH];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0]   count_ff, count_in;
   logic               push;
   cmd_type            new_cmd;

   function automatic logic [QPtrW-1:0] qptr_next(input logic [QPtrW-1:0] p);
      return (p == QPtrW'(CMDQ_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // classify the incoming item
   always_comb begin
      new_cmd            = '0;
      new_cmd.entry_id   = req_ch.entry_id;
      new_cmd.entry_code = req_ch.entry_code;
      if (req_ch.action) begin
         new_cmd.op = OP_SERVE;
      end else if (req_ch.to_high) begin
         new_cmd.op = OP_ADD_HIGH;
      end else begin
         new_cmd.op = OP_ADD_LOW;
      end
   end

   assign req_ch.ready = (count_ff != QCntW'(CMDQ_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != '0);
   assign cmd          = entry_ff[rd_ptr_ff];

   // advance pointers and count
   always_comb begin
      wr_ptr_in = push ? qptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? qptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the command
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

>>> sv/tlpf_back.sv
// Back end: run commands against the two ring buffers and register the response.
`include "two_level_priority_fifo_core_defines.svh"
module tlpf_back import tlpf_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  cmd_type      cmd,
   output logic         cmd_pop,
   tlpf_rsp_if.source   rsp_ch
);

   localparam int PtrW   = $clog2(QUEUE_DEPTH);
   localparam int CountW = $clog2(QUEUE_DEPTH + 1);
   localparam int EntryW = ID_W + CODE_W;

   back_state_type    state_ff, state_in;
   logic [PtrW-1:0]   high_head_ff, high_head_in, high_tail_ff, high_tail_in;
   logic [PtrW-1:0]   low_head_ff, low_head_in, low_tail_ff, low_tail_in;
   logic [CountW-1:0] high_fill_ff, high_fill_in, low_fill_ff, low_fill_in;
   logic              sel_high_ff, sel_high_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic              out_free, take, load, high_full, low_full;
   logic              high_wr_en, low_wr_en, high_rd_en, low_rd_en;
   logic [EntryW-1:0] wr_word, high_rd_data, low_rd_data, served_word;
   rsp_payload_type   res;

   function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
      return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CountW-1:0] f);
      logic [CountW+COUNT_OUT_W-1:0] wide;
      wide = {{COUNT_OUT_W{1'b0}}, f};
      return wide[COUNT_OUT_W-1:0];
   endfunction

   assign out_free    = !rsp_valid_ff || rsp_ch.ready;
   assign take        = (state_ff == BK_IDLE) && cmd_valid && out_free;
   assign cmd_pop     = take;
   assign high_full   = (high_fill_ff == CountW'(QUEUE_DEPTH));
   assign low_full    = (low_fill_ff == CountW'(QUEUE_DEPTH));
   assign wr_word     = {cmd.entry_id, cmd.entry_code};
   assign served_word = sel_high_ff ? high_rd_data : low_rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (take && cmd.op == OP_SERVE &&
                (high_fill_ff != '0 || low_fill_ff != '0)) begin
               state_in = BK_READ;
            end
         end
         BK_READ: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // queue updates and response build
   always_comb begin
      high_head_in = high_head_ff;
      high_tail_in = high_tail_ff;
      high_fill_in = high_fill_ff;
      low_head_in  = low_head_ff;
      low_tail_in  = low_tail_ff;
      low_fill_in  = low_fill_ff;
      sel_high_in  = sel_high_ff;
      high_wr_en   = 1'b0;
      low_wr_en    = 1'b0;
      high_rd_en   = 1'b0;
      low_rd_en    = 1'b0;
      load         = 1'b0;
      res          = '0;
      case (state_ff)
         BK_IDLE: begin
            if (take) begin
               case (cmd.op)
                  OP_ADD_HIGH: begin
                     load = 1'b1;
                     if (high_full) begin
                        res.status = ST_DROPPED;
                     end else begin
                        res.status   = ST_ADDED;
                        high_wr_en   = 1'b1;
                        high_tail_in = ptr_next(high_tail_ff);
                        high_fill_in = high_fill_ff + 1'b1;
                     end
                  end
                  OP_ADD_LOW: begin
                     load = 1'b1;
                     if (low_full) begin
                        res.status = ST_DROPPED;
                     end else begin
                        res.status  = ST_ADDED;
                        low_wr_en   = 1'b1;
                        low_tail_in = ptr_next(low_tail_ff);
                        low_fill_in = low_fill_ff + 1'b1;
                     end
                  end
                  OP_SERVE: begin
                     if (high_fill_ff != '0) begin
                        high_rd_en   = 1'b1;
                        high_head_in = ptr_next(high_head_ff);
                        high_fill_in = high_fill_ff - 1'b1;
                        sel_high_in  = 1'b1;
                     end else if (low_fill_ff != '0) begin
                        low_rd_en   = 1'b1;
                        low_head_in = ptr_next(low_head_ff);
                        low_fill_in = low_fill_ff - 1'b1;
                        sel_high_in = 1'b0;
                     end else begin
                        load       = 1'b1;
                        res.status = ST_EMPTY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_READ: begin
            if (out_free) begin
               load            = 1'b1;
               res.status      = ST_SERVED;
               res.from_high   = sel_high_ff;
               res.served_id   = served_word[EntryW-1:CODE_W];
               res.served_code = served_word[CODE_W-1:0];
            end
         end
         default: ;
      endcase
      res.high_count = count_out(high_fill_in);
      res.low_count  = count_out(low_fill_in);
      rsp_data_in    = load ? res : rsp_data_ff;
      rsp_valid_in   = load || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         high_head_ff <= '0;
         high_tail_ff <= '0;
         high_fill_ff <= '0;
         low_head_ff  <= '0;
         low_tail_ff  <= '0;
         low_fill_ff  <= '0;
         sel_high_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         high_head_ff <= high_head_in;
         high_tail_ff <= high_tail_in;
         high_fill_ff <= high_fill_in;
         low_head_ff  <= low_head_in;
         low_tail_ff  <= low_tail_in;
         low_fill_ff  <= low_fill_in;
         sel_high_ff  <= sel_high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   tlpf_ram #(.WIDTH(EntryW), .DEPTH(QUEUE_DEPTH)) u_high_ram (
      .clock   (clock),
      .wr_en   (high_wr_en),
      .wr_addr (high_tail_ff),
      .wr_data (wr_word),
      .rd_en   (high_rd_en),
      .rd_addr (high_head_ff),
      .rd_data (high_rd_data)
   );

   tlpf_ram #(.WIDTH(EntryW), .DEPTH(QUEUE_DEPTH)) u_low_ram (
      .clock   (clock),
      .wr_en   (low_wr_en),
      .wr_addr (low_tail_ff),
      .wr_data (wr_word),
      .rd_en   (low_rd_en),
      .rd_addr (low_head_ff),
      .rd_data (low_rd_data)
   );

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_data_ff.status;
   assign rsp_ch.from_high   = rsp_data_ff.from_high;
   assign rsp_ch.served_id   = rsp_data_ff.served_id;
   assign rsp_ch.served_code = rsp_data_ff.served_code;
   assign rsp_ch.high_count  = rsp_data_ff.high_count;
   assign rsp_ch.low_count   = rsp_data_ff.low_count;

   // fill counters never pass the depth
   `TLPF_ASSERT_SAME(a_high_fill_bound, clock, reset, 1'b1, high_fill_ff <= CountW'(QUEUE_DEPTH))
   `TLPF_ASSERT_SAME(a_low_fill_bound, clock, reset, 1'b1, low_fill_ff <= CountW'(QUEUE_DEPTH))
   // an empty ring has its head on its tail
   `TLPF_ASSERT_SAME(a_high_empty_ptrs, clock, reset, high_fill_ff == '0, high_head_ff == high_tail_ff)
   // no command is taken while a read completes
   `TLPF_ASSERT_SAME(a_no_pop_in_read, clock, reset, state_ff == BK_READ, !cmd_pop)
   // a serve of a non-empty high ring reads from the high RAM
   `TLPF_ASSERT_NEXT(a_serve_high, clock, reset, cmd_pop && cmd.op == OP_SERVE && high_fill_ff != '0, state_ff == BK_READ && sel_high_ff)

endmodule

>>> sv/two_level_priority_fifo_core.sv
// Top level of the two-level priority FIFO core.
//
//   channel   role    carries
//   req_ch    sink    action, to_high, entry_id, entry_code
//   rsp_ch    source  status, from_high, served_id, served_code, high_count, low_count
//
// An add, or a serve of two empty queues, is handled in the back end's idle state; a
// serve that finds an entry also passes the read state, as the ring buffer RAM has a
// registered read port. A two-entry command queue sits between front and back, so
// requests are taken while the back end works or a response waits for rsp_ch.ready.
// Reset is synchronous and empties both rings at once; no clearing pass is needed.
module two_level_priority_fifo_core import tlpf_pkg::*; #(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   tlpf_req_if.sink     req_ch,
   tlpf_rsp_if.source   rsp_ch
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   tlpf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   tlpf_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
